// ===== hdl/bffsa_pkg.sv =====
package bffsa_pkg;

    localparam int MAX_SLOTS = 256;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int CNT_W     = SLOT_W + 1;
    localparam int SUM_W     = SLOT_W + 2;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // register index, taken from paddr above the byte offset
    localparam logic REG_ACTIVE_SLOTS = 1'b0;
    localparam logic [CNT_W-1:0] ACTIVE_SLOTS_RESET = CNT_W'(MAX_SLOTS);

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_GROW  = 2'd2;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    localparam logic [1:0] STATUS_DONE       = 2'd0;
    localparam logic [1:0] STATUS_MOVED      = 2'd1;
    localparam logic [1:0] STATUS_NO_SPACE   = 2'd2;
    localparam logic [1:0] STATUS_NOT_LARGER = 2'd3;

    typedef struct packed {
        logic [1:0]       command;
        logic [SLOT_W-1:0] start_slot;
        logic [CNT_W-1:0]  count;
        logic [CNT_W-1:0]  new_count;
    } cmd_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  granted_count;
        logic [CNT_W-1:0]  slots_used;
    } rsp_t;

    typedef struct packed {
        logic shift;
        logic write;
        logic wbit;
    } map_ctrl_t;

endpackage

// ===== hdl/bffsa_map.sv =====
module bffsa_map
    import bffsa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  map_ctrl_t ctrl,
    output logic      cur_bit
);

    logic [MAX_SLOTS-1:0] map_reg;
    logic [MAX_SLOTS-1:0] map_next;
    logic                 in_bit;

    // slot under the head sits at bit 0; a full rotation restores the order
    assign cur_bit = map_reg[0];
    assign in_bit  = ctrl.write ? ctrl.wbit : map_reg[0];

    always_comb
    begin
        map_next = map_reg;
        if (ctrl.shift)
        begin
            map_next = {in_bit, map_reg[MAX_SLOTS-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg <= '0;
        end
        else
        begin
            map_reg <= map_next;
        end
    end

endmodule

// ===== hdl/bitmap_first_fit_slot_allocator.sv =====
// Contiguous slot allocator over a one-bit-per-slot occupancy map, first fit.
// Command channel (cmd_valid / cmd_stall / cmd_data) takes allocate, free and
// grow beats; the response channel (rsp_valid / rsp_stall / rsp_data) returns
// one beat per command with status, first slot, granted count and slots used.
// The map lives in a 256-bit rotating shift register and is read or written
// one slot per clock at its head, so every pass over it visits all 256 slots.
// Allocate and grow take a search pass, a decide step and a mark pass; a
// search that ends in no space skips the mark pass. Free takes one mark
// pass. Commands settled at once (no space up front, zero-size allocate,
// grow not larger) take no pass. One command is in work at a time;
// cmd_stall is high from accept until the result is handed to the output
// register, so a new command is taken while an earlier result still waits
// there. When rsp_stall is high the response beat holds and a finished
// command waits in its final state until the register frees up.
// Reset clears the map and the used count and sets active_slots to 256.
// active_slots is written through the APB port at address 0; the user must
// write it only while idle, as the block itself does not enforce this.
module bitmap_first_fit_slot_allocator
    import bffsa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  cmd_t                  cmd_data,

    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rsp_t                  rsp_data,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SEARCH = 5'b00010,
        ST_DECIDE = 5'b00100,
        ST_MARK   = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic              grow_reg, grow_next;
    logic [SLOT_W-1:0] start_reg, start_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  newc_reg, newc_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [CNT_W-1:0]  run_reg, run_next;
    logic              found_reg, found_next;
    logic [SLOT_W-1:0] pos_reg, pos_next;
    logic              blocked_reg, blocked_next;
    logic [SUM_W-1:0]  set_lo_reg, set_lo_next;
    logic [SUM_W-1:0]  set_hi_reg, set_hi_next;
    logic [SLOT_W-1:0] clr_lo_reg, clr_lo_next;
    logic [SUM_W-1:0]  clr_hi_reg, clr_hi_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic [SLOT_W-1:0] res_slot_reg, res_slot_next;
    logic [CNT_W-1:0]  res_granted_reg, res_granted_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [CNT_W-1:0]  active_reg, active_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_data_reg, rsp_data_next;

    map_ctrl_t         map_ctrl;
    logic              cur_bit;

    logic [CNT_W-1:0]  pool_n;
    logic              grow_zero;
    logic              in_alloc;
    logic              in_grow;
    logic [CNT_W-1:0]  in_len;
    logic              in_over;
    logic [SUM_W-1:0]  idx_w;
    logic              idx_last;
    logic              in_pool;
    logic [CNT_W-1:0]  run_inc;
    logic [SLOT_W-1:0] pos_cand;
    logic [SUM_W-1:0]  grow_lo;
    logic [SUM_W-1:0]  grow_hi;
    logic              in_window;
    logic              fits_in_place;
    logic              room_fail;
    logic              in_set;
    logic              in_clr;
    logic              new_bit;
    logic              out_free;
    logic              cfg_wr;

    bffsa_map u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (map_ctrl),
        .cur_bit (cur_bit)
    );

    assign pool_n = (active_reg > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : active_reg;

    assign grow_zero = (cmd_data.command == CMD_GROW) && (cmd_data.count == '0);
    assign in_alloc  = (cmd_data.command == CMD_ALLOC) || grow_zero;
    assign in_grow   = (cmd_data.command == CMD_GROW) && !grow_zero;
    // grow searches for a run of the new size
    assign in_len    = (cmd_data.command == CMD_GROW) ? cmd_data.new_count : cmd_data.count;
    assign in_over   = ({1'b0, used_reg} + {1'b0, in_len}) > {1'b0, pool_n};

    assign idx_w    = SUM_W'(idx_reg);
    assign idx_last = (idx_reg == SLOT_W'(MAX_SLOTS - 1));
    assign in_pool  = CNT_W'(idx_reg) < pool_n;
    assign run_inc  = run_reg + CNT_W'(1);
    assign pos_cand = SLOT_W'(CNT_W'(idx_reg) + CNT_W'(1) - len_reg);

    // slots that an in-place grow would claim
    assign grow_lo   = SUM_W'(start_reg) + SUM_W'(cnt_reg);
    assign grow_hi   = SUM_W'(start_reg) + SUM_W'(newc_reg);
    assign in_window = (idx_w >= grow_lo) && (idx_w < grow_hi);

    assign fits_in_place = (grow_hi <= SUM_W'(pool_n)) && !blocked_reg;
    assign room_fail     = (used_reg >= pool_n) || (newc_reg > (pool_n - used_reg));

    assign in_set  = (idx_w >= set_lo_reg) && (idx_w < set_hi_reg);
    assign in_clr  = (idx_w >= SUM_W'(clr_lo_reg)) && (idx_w < clr_hi_reg);
    assign new_bit = in_set ? 1'b1 : (in_clr ? 1'b0 : cur_bit);

    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        grow_next        = grow_reg;
        start_next       = start_reg;
        cnt_next         = cnt_reg;
        newc_next        = newc_reg;
        len_next         = len_reg;
        run_next         = run_reg;
        found_next       = found_reg;
        pos_next         = pos_reg;
        blocked_next     = blocked_reg;
        set_lo_next      = set_lo_reg;
        set_hi_next      = set_hi_reg;
        clr_lo_next      = clr_lo_reg;
        clr_hi_next      = clr_hi_reg;
        res_status_next  = res_status_reg;
        res_slot_next    = res_slot_reg;
        res_granted_next = res_granted_reg;
        used_next        = used_reg;
        rsp_valid_next   = rsp_valid_reg && rsp_stall;
        rsp_data_next    = rsp_data_reg;
        map_ctrl         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    grow_next    = in_grow;
                    start_next   = cmd_data.start_slot;
                    cnt_next     = cmd_data.count;
                    newc_next    = cmd_data.new_count;
                    len_next     = in_len;
                    run_next     = '0;
                    found_next   = 1'b0;
                    pos_next     = '0;
                    blocked_next = 1'b0;
                    idx_next     = '0;
                    if (in_alloc)
                    begin
                        res_status_next  = STATUS_NO_SPACE;
                        res_slot_next    = '0;
                        res_granted_next = '0;
                        if (in_over)
                        begin
                            state_next = ST_FINISH;
                        end
                        else if (in_len == '0)
                        begin
                            if (pool_n != '0)
                            begin
                                res_status_next = STATUS_DONE;
                            end
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            state_next = ST_SEARCH;
                        end
                    end
                    else if (in_grow)
                    begin
                        if (cmd_data.count >= cmd_data.new_count)
                        begin
                            res_status_next  = STATUS_NOT_LARGER;
                            res_slot_next    = cmd_data.start_slot;
                            res_granted_next = cmd_data.count;
                            state_next       = ST_FINISH;
                        end
                        else
                        begin
                            state_next = ST_SEARCH;
                        end
                    end
                    else
                    begin
                        // free, and the unused code, clear a range in one pass
                        set_lo_next      = '0;
                        set_hi_next      = '0;
                        clr_lo_next      = cmd_data.start_slot;
                        clr_hi_next      = SUM_W'(cmd_data.start_slot)
                                           + SUM_W'(cmd_data.count);
                        res_status_next  = STATUS_DONE;
                        res_slot_next    = cmd_data.start_slot;
                        res_granted_next = '0;
                        state_next       = ST_MARK;
                    end
                end
            end

            ST_SEARCH:
            begin
                map_ctrl.shift = 1'b1;
                idx_next       = idx_reg + SLOT_W'(1);
                if (!found_reg)
                begin
                    if (in_pool && !cur_bit)
                    begin
                        run_next = run_inc;
                        if (run_inc == len_reg)
                        begin
                            found_next = 1'b1;
                            pos_next   = pos_cand;
                        end
                    end
                    else
                    begin
                        run_next = '0;
                    end
                end
                if (in_window && cur_bit)
                begin
                    blocked_next = 1'b1;
                end
                if (idx_last)
                begin
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                clr_lo_next = start_reg;
                clr_hi_next = '0;
                state_next  = ST_MARK;
                if (!grow_reg)
                begin
                    if (found_reg)
                    begin
                        set_lo_next      = SUM_W'(pos_reg);
                        set_hi_next      = SUM_W'(pos_reg) + SUM_W'(len_reg);
                        res_status_next  = STATUS_DONE;
                        res_slot_next    = pos_reg;
                        res_granted_next = len_reg;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
                else if (fits_in_place)
                begin
                    set_lo_next      = grow_lo;
                    set_hi_next      = grow_hi;
                    res_status_next  = STATUS_DONE;
                    res_slot_next    = start_reg;
                    res_granted_next = newc_reg;
                end
                else if (room_fail || !found_reg)
                begin
                    res_status_next  = STATUS_NO_SPACE;
                    res_slot_next    = start_reg;
                    res_granted_next = cnt_reg;
                    state_next       = ST_FINISH;
                end
                else
                begin
                    // move: release the old block and claim the new run together
                    set_lo_next      = SUM_W'(pos_reg);
                    set_hi_next      = SUM_W'(pos_reg) + SUM_W'(newc_reg);
                    clr_hi_next      = grow_lo;
                    res_status_next  = STATUS_MOVED;
                    res_slot_next    = pos_reg;
                    res_granted_next = newc_reg;
                end
            end

            ST_MARK:
            begin
                map_ctrl.shift = 1'b1;
                map_ctrl.write = 1'b1;
                map_ctrl.wbit  = new_bit;
                idx_next       = idx_reg + SLOT_W'(1);
                if (new_bit && !cur_bit)
                begin
                    used_next = used_reg + CNT_W'(1);
                end
                else if (!new_bit && cur_bit && (used_reg != '0))
                begin
                    used_next = used_reg - CNT_W'(1);
                end
                if (idx_last)
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    rsp_valid_next              = 1'b1;
                    rsp_data_next.status        = res_status_reg;
                    rsp_data_next.slot          = res_slot_reg;
                    rsp_data_next.granted_count = res_granted_reg;
                    rsp_data_next.slots_used    = used_reg;
                    state_next                  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[APB_ADDR_W-1] == REG_ACTIVE_SLOTS);

    always_comb
    begin
        active_next = active_reg;
        if (cfg_wr)
        begin
            active_next = pwdata[CNT_W-1:0];
        end
    end

    assign prdata = (paddr[APB_ADDR_W-1] == REG_ACTIVE_SLOTS)
                    ? APB_DATA_W'(active_reg) : '0;
    assign pready = 1'b1;

    assign cmd_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            used_reg      <= '0;
            active_reg    <= ACTIVE_SLOTS_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            used_reg      <= used_next;
            active_reg    <= active_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        grow_reg        <= grow_next;
        start_reg       <= start_next;
        cnt_reg         <= cnt_next;
        newc_reg        <= newc_next;
        len_reg         <= len_next;
        run_reg         <= run_next;
        found_reg       <= found_next;
        pos_reg         <= pos_next;
        blocked_reg     <= blocked_next;
        set_lo_reg      <= set_lo_next;
        set_hi_reg      <= set_hi_next;
        clr_lo_reg      <= clr_lo_next;
        clr_hi_reg      <= clr_hi_next;
        res_status_reg  <= res_status_next;
        res_slot_reg    <= res_slot_next;
        res_granted_reg <= res_granted_next;
        rsp_data_reg    <= rsp_data_next;
    end

endmodule
